[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the MIDI channel message parser.
// Each macro samples on clock; the disabled form ignores cycles in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, suspended while reset is high.
`define MCMP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define MCMP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/mcmp_pkg.sv]
// Shared types and constants for the MIDI channel message parser.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package mcmp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned DATA_W    = 7;
   localparam int unsigned PHASE_W   = 4;
   localparam int unsigned CHAN_W    = 4;
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned QUIET_W   = 17;
   localparam int unsigned TIMEOUT_W = 16;

   // status byte upper nibble, less its top bit
   localparam logic [KIND_W-1:0] KIND_PROGRAM   = 3'd4; // 0xC program change
   localparam logic [KIND_W-1:0] KIND_PRESSURE  = 3'd5; // 0xD channel aftertouch
   localparam logic [KIND_W-1:0] KIND_SYSTEM    = 3'd7; // 0xF system / realtime

   // phase 0 is idle; 1+2k awaits first data, 2+2k awaits second
   localparam logic [PHASE_W-1:0] PHASE_IDLE = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd14;

   localparam logic [QUIET_W-1:0]   QUIET_MAX     = 17'h1FFFF;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

   typedef struct packed {
      logic              is_tick;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] status;
      logic [DATA_W-1:0] data1;
      logic [DATA_W-1:0] data2;
   } result_type;

endpackage

[rtl/mcmp_in_reg.sv]
// Input register of the MIDI channel message parser.
// Depends on mcmp_pkg for the request item type.
`timescale 1ns / 1ps

module mcmp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,      // request accepted this cycle
   input  mcmp_pkg::req_item_type item_in,
   input  logic                  take,      // held request consumed this cycle
   output logic                  valid,
   output mcmp_pkg::req_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   mcmp_pkg::req_item_type item_ff;

   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

[rtl/mcmp_core.sv]
// Parser state and next-state logic: running status, data slots, silence timer.
// Depends on mcmp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcmp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [15:0]            csr_value,
   input  logic                   step,       // process the held request
   input  mcmp_pkg::req_item_type item,
   output logic                   res_valid,
   output mcmp_pkg::result_type   result
);

   logic [mcmp_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [mcmp_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [mcmp_pkg::CHAN_W-1:0]    chan_ff, chan_in;
   logic [mcmp_pkg::DATA_W-1:0]    first_ff, first_in;
   logic [mcmp_pkg::DATA_W-1:0]    second_ff, second_in;
   logic [mcmp_pkg::QUIET_W-1:0]   quiet_ff, quiet_in;

   logic [mcmp_pkg::PHASE_W-1:0]   phase_m1;
   logic [mcmp_pkg::KIND_W-1:0]    cur_kind;
   logic [mcmp_pkg::KIND_W-1:0]    rx_kind;
   logic                           await_second;
   logic                           single;
   logic                           emit;

   assign phase_m1     = phase_ff - 4'd1;
   assign cur_kind     = phase_m1[3:1];
   assign await_second = phase_m1[0];
   assign single       = (cur_kind == mcmp_pkg::KIND_PROGRAM) ||
                         (cur_kind == mcmp_pkg::KIND_PRESSURE);
   assign rx_kind      = item.rx_byte[6:4];

   always_comb begin
      phase_in  = phase_ff;
      chan_in   = chan_ff;
      first_in  = first_ff;
      second_in = second_ff;
      quiet_in  = quiet_ff;
      emit      = 1'b0;
      if (step) begin
         if (item.is_tick) begin
            if (quiet_ff != mcmp_pkg::QUIET_MAX) begin
               quiet_in = quiet_ff + 17'd1;
            end
            if (quiet_in > {1'b0, timeout_ff}) begin
               phase_in  = mcmp_pkg::PHASE_IDLE;
               chan_in   = '0;
               first_in  = '0;
               second_in = '0;
            end
         end else begin
            quiet_in = '0;
            if (item.rx_byte[7]) begin
               if (rx_kind == mcmp_pkg::KIND_SYSTEM) begin
                  phase_in  = mcmp_pkg::PHASE_IDLE;
                  chan_in   = '0;
                  first_in  = '0;
                  second_in = '0;
               end else begin
                  chan_in  = item.rx_byte[3:0];
                  phase_in = {rx_kind, 1'b1};
               end
            end else if ((phase_ff == mcmp_pkg::PHASE_IDLE) ||
                         (phase_ff > mcmp_pkg::PHASE_LAST)) begin
               phase_in = mcmp_pkg::PHASE_IDLE;
            end else if (single) begin
               first_in = item.rx_byte[6:0];
               emit     = 1'b1;
            end else if (!await_second) begin
               first_in = item.rx_byte[6:0];
               phase_in = phase_ff + 4'd1;
            end else begin
               second_in = item.rx_byte[6:0];
               phase_in  = phase_ff - 4'd1;
               emit      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= mcmp_pkg::TIMEOUT_RESET;
         phase_ff   <= mcmp_pkg::PHASE_IDLE;
         chan_ff    <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
         quiet_ff   <= '0;
      end else begin
         if (csr_write) begin
            timeout_ff <= csr_value;
         end
         phase_ff  <= phase_in;
         chan_ff   <= chan_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         quiet_ff  <= quiet_in;
      end
   end

   assign res_valid     = emit;
   assign result.status = {1'b1, cur_kind, chan_ff};
   assign result.data1  = first_in;
   assign result.data2  = second_in;

   `MCMP_ASSERT(a_phase_legal, (phase_ff != 4'd15), "parser phase out of range")
   `MCMP_ASSERT(a_quiet_cleared, ((step && !item.is_tick) |=> (quiet_ff == '0)), "silence timer not cleared by a byte")
   `MCMP_ASSERT(a_emit_on_data, (res_valid |-> (step && !item.is_tick && !item.rx_byte[7])), "result without a data byte")

endmodule

[rtl/mcmp_out_reg.sv]
// Result register of the MIDI channel message parser.
// Depends on mcmp_pkg for the result type.
`timescale 1ns / 1ps

module mcmp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  mcmp_pkg::result_type result,
   input  logic                 out_ready,
   output logic                 space,     // register free or draining
   output logic                 out_valid,
   output mcmp_pkg::result_type out_result
);

   logic                 valid_ff;
   mcmp_pkg::result_type result_ff;

   assign space = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (space) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (space && res_valid) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

[rtl/midi_channel_message_parser_unit.sv]
// Top level of the MIDI channel message parser with running status.
// Depends on mcmp_pkg, mcmp_in_reg, mcmp_core, mcmp_out_reg, assert_macros.svh.
//
// channel   dir  handshake            payload
// req_      in   req_tvalid/tready    tdata rx_byte, tuser is_tick
// rsp_      out  rsp_tvalid/tready    tdata status, data1, data2
// csr_      in   csr_valid/ready      csr_data timeout_ms (ms)
//
// One request per cycle sustained while rsp_ is not stalled; a request is held in the input
// register and its message, if any, shows on rsp_ the cycle after the request is processed.
// Throughput is set by the state update in mcmp_core.
// Reset (synchronous, high) clears both registers, the parser state and
// sets timeout_ms to 100. A stalled rsp_ holds the message; req_tready
// drops only when the input and result registers are both occupied and rsp_ stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module midi_channel_message_parser_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] is_tick
   // message channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] status, [14:8] data1, [21:15] data2, rest 0
   // timeout register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   mcmp_pkg::req_item_type req_item;
   mcmp_pkg::req_item_type held_item;
   mcmp_pkg::result_type   core_result;
   mcmp_pkg::result_type   rsp_result;
   logic                   held_valid;
   logic                   out_space;
   logic                   step;
   logic                   core_valid;
   logic                   req_take;

   assign req_item.is_tick = req_tuser;
   assign req_item.rx_byte = req_tdata;

   // a held request is processed as soon as the result register can take
   // whatever it produces, even when it produces nothing
   assign step       = held_valid & out_space;
   assign req_tready = ~held_valid | out_space;
   assign req_take   = req_tvalid & req_tready;

   // register is always writable; the user must write it only while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   mcmp_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (req_take),
      .item_in (req_item),
      .take    (step),
      .valid   (held_valid),
      .item    (held_item)
   );

   mcmp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_value (csr_data),
      .step      (step),
      .item      (held_item),
      .res_valid (core_valid),
      .result    (core_result)
   );

   mcmp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (core_valid),
      .result     (core_result),
      .out_ready  (rsp_tready),
      .space      (out_space),
      .out_valid  (rsp_tvalid),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {2'b00, rsp_result.data2, rsp_result.data1, rsp_result.status};

   // only channel voice kinds 0x8..0xE ever leave the block
   `MCMP_ASSERT(a_rsp_voice, (rsp_tvalid |-> (rsp_tdata[7] && (rsp_tdata[6:4] != 3'b111))), "non-voice status on rsp")
   // a full pipeline must refuse new requests
   `MCMP_ASSERT(a_full_stalls, ((held_valid && rsp_tvalid && !rsp_tready) |-> !req_tready), "request taken while full")

endmodule

[sim/midi_channel_message_parser_unit_test.sv]
// Self-checking bench for midi_channel_message_parser_unit: a directed table, then
// random MIDI streams, checked against an in-bench parser model or typed table rows.
// Depends on mcmp_pkg (rtl/mcmp_pkg.sv) and the RTL under rtl/.
`timescale 1ns / 1ps

module midi_channel_message_parser_unit_test;

   localparam int    HALF_PERIOD = 10;
   localparam int    SETTLE      = 8;           // pipeline depth plus margin
   localparam int    PHASE_ITEMS = 50;
   localparam int    PHASES      = 8;
   localparam longint LIMIT_NS   = 64'd20_000_000;

   // what a directed row does
   typedef enum logic [1:0] {
      ROW_NONE, // request, no message may follow
      ROW_MSG,  // request, message typed into the row
      ROW_PRED, // request, message taken from the model
      ROW_TMO   // timeout register write
   } row_action_type;

   typedef struct packed {
      row_action_type              action;
      logic                        tick;
      logic [7:0]                  rx;
      logic [7:0]                  status;
      logic [mcmp_pkg::DATA_W-1:0] d1;
      logic [mcmp_pkg::DATA_W-1:0] d2;
      logic [15:0]                 tmo;
   } stim_row_type;

   localparam int ROWS = 34;

   // directed table
   stim_row_type stim_rows [0:ROWS-1] = '{
      '{ROW_NONE, 1'b0, 8'h45, 8'h00, 7'h00, 7'h00, 16'd0}, // data while idle
      '{ROW_NONE, 1'b0, 8'h90, 8'h00, 7'h00, 7'h00, 16'd0}, // note on, ch 0
      '{ROW_NONE, 1'b0, 8'h00, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_MSG,  1'b0, 8'h7F, 8'h90, 7'h00, 7'h7F, 16'd0},
      '{ROW_NONE, 1'b0, 8'h7F, 8'h00, 7'h00, 7'h00, 16'd0}, // running status
      '{ROW_MSG,  1'b0, 8'h00, 8'h90, 7'h7F, 7'h00, 16'd0},
      '{ROW_NONE, 1'b0, 8'h80, 8'h00, 7'h00, 7'h00, 16'd0}, // lowest status
      '{ROW_NONE, 1'b0, 8'h12, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_PRED, 1'b0, 8'h34, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_NONE, 1'b0, 8'hC3, 8'h00, 7'h00, 7'h00, 16'd0}, // program change
      '{ROW_MSG,  1'b0, 8'h05, 8'hC3, 7'h05, 7'h34, 16'd0}, // stale second data
      '{ROW_NONE, 1'b0, 8'hD9, 8'h00, 7'h00, 7'h00, 16'd0}, // channel pressure
      '{ROW_MSG,  1'b0, 8'h7F, 8'hD9, 7'h7F, 7'h34, 16'd0},
      '{ROW_PRED, 1'b0, 8'hA1, 8'h00, 7'h00, 7'h00, 16'd0}, // poly pressure
      '{ROW_PRED, 1'b0, 8'h11, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_PRED, 1'b0, 8'h22, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_NONE, 1'b0, 8'hEF, 8'h00, 7'h00, 7'h00, 16'd0}, // highest status
      '{ROW_NONE, 1'b0, 8'h7F, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_MSG,  1'b0, 8'h7F, 8'hEF, 7'h7F, 7'h7F, 16'd0},
      '{ROW_NONE, 1'b0, 8'hB2, 8'h00, 7'h00, 7'h00, 16'd0}, // control change
      '{ROW_NONE, 1'b0, 8'h01, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_NONE, 1'b0, 8'hFF, 8'h00, 7'h00, 7'h00, 16'd0}, // system byte clears
      '{ROW_NONE, 1'b0, 8'h22, 8'h00, 7'h00, 7'h00, 16'd0}, // idle again
      '{ROW_NONE, 1'b0, 8'hC0, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_MSG,  1'b0, 8'h01, 8'hC0, 7'h01, 7'h00, 16'd0}, // cleared second data
      '{ROW_TMO,  1'b0, 8'h00, 8'h00, 7'h00, 7'h00, 16'd1},
      '{ROW_NONE, 1'b0, 8'h9A, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_NONE, 1'b1, 8'hA5, 8'h00, 7'h00, 7'h00, 16'd0}, // silence of 1 ms
      '{ROW_NONE, 1'b1, 8'h5A, 8'h00, 7'h00, 7'h00, 16'd0}, // 2 ms: timeout
      '{ROW_NONE, 1'b0, 8'h20, 8'h00, 7'h00, 7'h00, 16'd0}, // ignored
      '{ROW_TMO,  1'b0, 8'h00, 8'h00, 7'h00, 7'h00, 16'd0}, // zero timeout
      '{ROW_NONE, 1'b0, 8'h9B, 8'h00, 7'h00, 7'h00, 16'd0},
      '{ROW_NONE, 1'b1, 8'h00, 8'h00, 7'h00, 7'h00, 16'd0}, // first tick resets
      '{ROW_NONE, 1'b0, 8'h10, 8'h00, 7'h00, 7'h00, 16'd0}
   };

   // DUT connections, inputs driven from time zero
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] rx_byte
   logic        req_tuser  = 1'b0;   // [0] is_tick
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;           // [7:0] status, [14:8] data1, [21:15] data2
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = 16'd0;

   // parser model state, reset values
   logic [mcmp_pkg::PHASE_W-1:0]   phase_q   = mcmp_pkg::PHASE_IDLE;
   logic [mcmp_pkg::CHAN_W-1:0]    chan_q    = '0;
   logic [mcmp_pkg::DATA_W-1:0]    first_q   = '0;
   logic [mcmp_pkg::DATA_W-1:0]    second_q  = '0;
   logic [mcmp_pkg::QUIET_W-1:0]   quiet_q   = '0;
   logic [mcmp_pkg::TIMEOUT_W-1:0] tmo_limit = mcmp_pkg::TIMEOUT_RESET;

   mcmp_pkg::result_type due_messages [$];
   int                   mismatch_count = 0;
   int                   sender_idle_pct = 0;
   int                   receiver_stall_pct = 0;
   row_action_type       req_mode = ROW_PRED;   // how the pending request is checked
   mcmp_pkg::result_type req_typed;             // typed message for ROW_MSG rows

   midi_channel_message_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // Run guard: a hang anywhere ends the run as a failure.
   initial begin
      #(LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [23:0] got,
                                input logic [23:0] want);
      $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Phase, channel and both data slots go back to reset values.
   function automatic void clear_parser();
      phase_q  = mcmp_pkg::PHASE_IDLE;
      chan_q   = '0;
      first_q  = '0;
      second_q = '0;
   endfunction

   // Advances the model by one request; returns 1 when a message completes.
   function automatic bit parse_midi_byte(input logic tick, input logic [7:0] b,
                                          output mcmp_pkg::result_type msg);
      logic [mcmp_pkg::KIND_W-1:0]  kind;
      logic [mcmp_pkg::PHASE_W-1:0] slot;
      parse_midi_byte = 1'b0;
      msg = '0;
      if (tick) begin
         if (quiet_q != mcmp_pkg::QUIET_MAX) quiet_q++;
         if (quiet_q > {1'b0, tmo_limit}) clear_parser();
         return parse_midi_byte;
      end
      quiet_q = '0;
      if (b[7]) begin
         kind = b[6:4];
         if (kind == mcmp_pkg::KIND_SYSTEM) begin
            clear_parser();
         end else begin
            chan_q  = b[3:0];
            phase_q = {kind, 1'b1};      // awaiting first data of this kind
         end
         return parse_midi_byte;
      end
      if (phase_q == mcmp_pkg::PHASE_IDLE || phase_q > mcmp_pkg::PHASE_LAST) begin
         phase_q = mcmp_pkg::PHASE_IDLE;
         return parse_midi_byte;
      end
      slot = phase_q - 4'd1;
      kind = slot[3:1];
      if (kind == mcmp_pkg::KIND_PROGRAM || kind == mcmp_pkg::KIND_PRESSURE) begin
         first_q = b[6:0];
         parse_midi_byte = 1'b1;
      end else if (!slot[0]) begin
         first_q = b[6:0];
         phase_q = {kind, 1'b1} + 4'd1;
      end else begin
         second_q = b[6:0];
         phase_q  = {kind, 1'b1};        // running status: back to first data
         parse_midi_byte = 1'b1;
      end
      if (parse_midi_byte) begin
         msg.status = {1'b1, kind, chan_q};
         msg.data1  = first_q;
         msg.data2  = second_q;
      end
   endfunction

   // Scoreboard: compare finished messages, then track writes and requests.
   always @(posedge clock) begin
      mcmp_pkg::result_type want;
      mcmp_pkg::result_type made;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_messages.size() == 0) begin
               flag_mismatch("unexpected message", rsp_tdata, 24'd0);
            end else begin
               want = due_messages.pop_front();
               if (rsp_tdata[7:0] !== want.status)
                  flag_mismatch("status", 24'(rsp_tdata[7:0]), 24'(want.status));
               if (rsp_tdata[14:8] !== want.data1)
                  flag_mismatch("data1", 24'(rsp_tdata[14:8]), 24'(want.data1));
               if (rsp_tdata[21:15] !== want.data2)
                  flag_mismatch("data2", 24'(rsp_tdata[21:15]), 24'(want.data2));
            end
         end
         if (csr_valid && csr_ready) tmo_limit = csr_data;
         if (req_tvalid && req_tready) begin
            if (parse_midi_byte(req_tuser, req_tdata, made) && req_mode == ROW_PRED)
               due_messages.push_back(made);
            if (req_mode == ROW_MSG) due_messages.push_back(req_typed);
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Entered and left at a falling edge; holds tvalid high until accepted.
   task automatic send_request(input logic tick, input logic [7:0] b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= tick;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // Stops sending until every expected message is out, then waits out the settle margin.
   task automatic wait_for_messages(input int settle);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (due_messages.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly complete messages with running status, sprinkled with silence;
   // the rest is system bytes, stray data and raw noise. Ticks count as items.
   task automatic run_random_phase(input int n_items);
      int sent;
      int choice;
      int run;
      int ticks;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         if (!paused && sent >= n_items / 2) begin
            wait_for_messages(0);   // hold off until the pipe is empty
            paused = 1'b1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 70) begin
            send_request(1'b0, 8'($urandom_range(8'h80, 8'hEF)));
            sent++;
            run = $urandom_range(1, 6);
            repeat (run) begin
               if ($urandom_range(0, 99) < 15) begin
                  ticks = $urandom_range(1, 4);
                  send_ticks(ticks);
                  sent += ticks;
               end
               send_request(1'b0, 8'($urandom_range(0, 127)));
               sent++;
            end
         end else if (choice < 78) begin
            // silence just past the limit where that is cheap
            ticks = (tmo_limit <= 40) ? int'(tmo_limit) + 1 : 3;
            send_ticks(ticks);
            sent += ticks;
         end else if (choice < 86) begin
            send_request(1'b0, 8'($urandom_range(8'hF0, 8'hFF)));
            sent++;
         end else if (choice < 93) begin
            send_request(1'b0, 8'($urandom_range(0, 127)));
            sent++;
         end else begin
            send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   initial begin
      logic [15:0] phase_tmo [PHASES];
      phase_tmo = '{16'hFFFF, 16'd3, 16'd0, 16'd0, 16'd20, 16'd7, 16'd0, 16'd1};
      phase_tmo[2] = 16'($urandom_range(1, 65535));
      phase_tmo[6] = 16'($urandom_range(1, 30));

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, no idling, reset timeout until the first write row
      for (int i = 0; i < ROWS; i++) begin
         if (stim_rows[i].action == ROW_TMO) begin
            wait_for_messages(SETTLE);
            write_timeout(stim_rows[i].tmo);
         end else begin
            req_mode  = stim_rows[i].action;
            req_typed = '{stim_rows[i].status, stim_rows[i].d1, stim_rows[i].d2};
            send_request(stim_rows[i].tick, stim_rows[i].rx);
         end
      end
      req_mode = ROW_PRED;

      // random phases, each with its own timeout and idling pattern
      for (int p = 0; p < PHASES; p++) begin
         wait_for_messages(SETTLE);
         write_timeout(phase_tmo[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
         endcase
         run_random_phase(PHASE_ITEMS);
      end

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      wait_for_messages(SETTLE);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[midi_channel_message_parser_unit.f]
+incdir+rtl
rtl/mcmp_pkg.sv
rtl/mcmp_in_reg.sv
rtl/mcmp_core.sv
rtl/mcmp_out_reg.sv
rtl/midi_channel_message_parser_unit.sv
sim/midi_channel_message_parser_unit_test.sv
